// ===== rtl/swds_pkg.sv =====
`timescale 1ns / 1ps

package swds_pkg;

  // Revolution size and the position wrap limit (pos is 12 bits wide).
  localparam int STEPS_PER_REV = 2048;
  localparam int POS_LIMIT     = (STEPS_PER_REV < 2048) ? STEPS_PER_REV : 2048;

  localparam int POS_W   = 12;
  localparam int CNT_W   = 32;
  localparam int IVL_W   = 16;
  localparam int COIL_W  = 4;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [IVL_W-1:0] STEP_INTERVAL_RST = 16'd2;
  localparam logic [IVL_W-1:0] ELAPSED_MAX       = 16'hFFFF;

  // Item kinds.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_MOVE = 1'b1;

  // Move directions.
  localparam logic DIR_CCW = 1'b0;
  localparam logic DIR_CW  = 1'b1;

  // Register word index, taken from paddr[2].
  localparam logic REG_STEP_INTERVAL = 1'b0;

  // Position limits in one bit more than the position itself.
  localparam logic signed [POS_W:0] POS_LIM_HI = (POS_W + 1)'(POS_LIMIT);
  localparam logic signed [POS_W:0] POS_LIM_LO = -((POS_W + 1)'(POS_LIMIT));

endpackage

// ===== rtl/stepper_wave_drive_sequencer.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// in        sink       in_valid_i / in_stall_o  kind_i, step_count_i, move_dir_i
// out       source     out_valid_o / out_stall_i coil_drive_o, running_o,
//                                               position_o, steps_remaining_o
// cfg       APB slave  psel/penable/pready     paddr, pwdata, prdata
//
// One item per cycle sustained while the output is not stalled; each result passes
// through the input register, then the result register.
// The stepping state is updated once per item as it moves into the result
// register. Reset clears the stepping state and valid bits, sets step_interval to 2.
// A stall on the output holds the result register, then the input register;
// in_stall_o rises only when both are full.

module stepper_wave_drive_sequencer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 kind_i,
  input  logic [swds_pkg::CNT_W-1:0]           step_count_i,
  input  logic                                 move_dir_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [swds_pkg::COIL_W-1:0]          coil_drive_o,
  output logic                                 running_o,
  output logic signed [swds_pkg::POS_W-1:0]    position_o,
  output logic [swds_pkg::CNT_W-1:0]           steps_remaining_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [swds_pkg::PADDR_W-1:0]         paddr,
  input  logic [swds_pkg::PDATA_W-1:0]         pwdata,
  output logic [swds_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready
);

  // Configuration register.
  logic [swds_pkg::IVL_W-1:0] step_interval_q;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == swds_pkg::REG_STEP_INTERVAL);

  always_comb begin
    prdata = '0;
    if (paddr[2] == swds_pkg::REG_STEP_INTERVAL) begin
      prdata = {{(swds_pkg::PDATA_W - swds_pkg::IVL_W){1'b0}}, step_interval_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_interval_q <= swds_pkg::STEP_INTERVAL_RST;
    end else if (cfg_wr) begin
      step_interval_q <= pwdata[swds_pkg::IVL_W-1:0];
    end
  end

  // Input register.
  logic                       s1_valid_q;
  logic                       s1_kind_q;
  logic [swds_pkg::CNT_W-1:0] s1_count_q;
  logic                       s1_dir_q;
  logic                       out_valid_q;
  logic                       advance;
  logic                       in_xfer;
  logic                       s2_fire;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign s2_fire    = s1_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s2_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_kind_q  <= kind_i;
      s1_count_q <= step_count_i;
      s1_dir_q   <= move_dir_i;
    end
  end

  // Stepping state.
  logic [swds_pkg::CNT_W-1:0]        remaining_q, remaining_d;
  logic                              dir_q, dir_d;
  logic [swds_pkg::IVL_W-1:0]        elapsed_q, elapsed_d;
  logic [1:0]                        phase_q, phase_d;
  logic signed [swds_pkg::POS_W-1:0] pos_q, pos_d;
  logic [swds_pkg::COIL_W-1:0]       coils_q, coils_d;

  logic [swds_pkg::IVL_W-1:0]        elapsed_inc;
  logic signed [swds_pkg::POS_W:0]   pos_step;
  logic                              take_step;

  always_comb begin
    remaining_d = remaining_q;
    dir_d       = dir_q;
    elapsed_d   = elapsed_q;
    phase_d     = phase_q;
    pos_d       = pos_q;
    coils_d     = coils_q;

    elapsed_inc = (elapsed_q == swds_pkg::ELAPSED_MAX) ? elapsed_q
                                                        : elapsed_q + 1'b1;
    take_step   = (remaining_q != '0) && (elapsed_inc >= step_interval_q);
    if (dir_q == swds_pkg::DIR_CW) begin
      pos_step = {pos_q[swds_pkg::POS_W-1], pos_q} - (swds_pkg::POS_W + 1)'(1);
    end else begin
      pos_step = {pos_q[swds_pkg::POS_W-1], pos_q} + (swds_pkg::POS_W + 1)'(1);
    end

    if (s1_kind_q == swds_pkg::KIND_MOVE) begin
      remaining_d = s1_count_q;
      dir_d       = s1_dir_q;
    end else begin
      elapsed_d = elapsed_inc;
      if (take_step) begin
        // Phase always advances; direction only picks which coil it maps to.
        if (dir_q == swds_pkg::DIR_CW) begin
          coils_d = swds_pkg::COIL_W'(1) << phase_q;
        end else begin
          coils_d = swds_pkg::COIL_W'(1) << (~phase_q);
        end
        if (pos_step >= swds_pkg::POS_LIM_HI || pos_step <= swds_pkg::POS_LIM_LO) begin
          pos_d = '0;
        end else begin
          pos_d = pos_step[swds_pkg::POS_W-1:0];
        end
        phase_d     = phase_q + 2'd1;
        remaining_d = remaining_q - 1'b1;
        elapsed_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
      dir_q       <= swds_pkg::DIR_CCW;
      elapsed_q   <= '0;
      phase_q     <= '0;
      pos_q       <= '0;
      coils_q     <= '0;
    end else if (s2_fire) begin
      remaining_q <= remaining_d;
      dir_q       <= dir_d;
      elapsed_q   <= elapsed_d;
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      coils_q     <= coils_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      coil_drive_o      <= coils_d;
      running_o         <= (remaining_d != '0);
      position_o        <= pos_d;
      steps_remaining_o <= remaining_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/swds_checker.sv =====
`timescale 1ns / 1ps

module swds_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [swds_pkg::COIL_W-1:0]       coil_drive_o,
  input logic                              running_o,
  input logic signed [swds_pkg::POS_W-1:0] position_o,
  input logic [swds_pkg::CNT_W-1:0]        steps_remaining_o
);

  // A stalled result stays offered with its count, position and coils unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(steps_remaining_o) &&
      $stable(position_o) && $stable(coil_drive_o))
    else $error("stalled result changed");

  // Wave drive never energizes more than one coil.
  a_one_coil: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(coil_drive_o))
    else $error("more than one coil driven");

  a_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> running_o == (steps_remaining_o != '0))
    else $error("running flag disagrees with remaining count");

  // The position wraps before reaching the most negative code.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> position_o != {1'b1, {(swds_pkg::POS_W - 1){1'b0}}})
    else $error("position out of range");

endmodule

bind stepper_wave_drive_sequencer swds_checker u_swds_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .coil_drive_o      (coil_drive_o),
  .running_o         (running_o),
  .position_o        (position_o),
  .steps_remaining_o (steps_remaining_o)
);
